FILE: hw/rtl/paged_mmu_frame_allocator_unit_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef PAGED_MMU_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define PAGED_MMU_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PMFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmfa check failed");
`define PMFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmfa check failed");
`else
`define PMFA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PMFA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/pmfa_pkg.sv
// Shared types and constants of the paged MMU frame allocator.
package pmfa_pkg;

    localparam int PROCESSES_DEF   = 64;
    localparam int PAGES_DEF       = 1024;
    localparam int FRAME_COUNT_DEF = 4096;
    localparam logic [11:0] FIRST_FRAME_RST = 12'd16;
    localparam int FCNT_W = 17;

    localparam logic [2:0] CMD_MAP     = 3'd0;
    localparam logic [2:0] CMD_UNMAP   = 3'd1;
    localparam logic [2:0] CMD_READ    = 3'd2;
    localparam logic [2:0] CMD_WRITE   = 3'd3;
    localparam logic [2:0] CMD_RELEASE = 3'd4;

    typedef enum logic [2:0] {
        K_NOP    = 3'd0,
        K_BADPID = 3'd1,
        K_MAP    = 3'd2,
        K_UNMAP  = 3'd3,
        K_READ   = 3'd4,
        K_WRITE  = 3'd5,
        K_REL    = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  pid;
        logic [9:0]  vpn;
        logic [11:0] offset;
        logic [10:0] count;
        logic [2:0]  flags;
        logic [7:0]  wbyte;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_out;

    typedef struct packed {
        logic pop;
        logic init_done;
    } t_back_stat;

endpackage

FILE: hw/rtl/pmfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pmfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/pmfa_front.sv
// Front end: classify incoming commands and queue them for the sequencer.
`include "paged_mmu_frame_allocator_unit_macros.svh"
module pmfa_front #(
    parameter int PROCESSES = pmfa_pkg::PROCESSES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_cmd,
    input  logic [5:0]            i_pid,
    input  logic [21:0]           i_vaddr,
    input  logic [10:0]           i_page_count,
    input  logic [2:0]            i_flags,
    input  logic [7:0]            i_write_byte,
    input  pmfa_pkg::t_back_stat  i_stat,
    output pmfa_pkg::t_q_out      o_q
);
    pmfa_pkg::t_item r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt, n_cnt;
    pmfa_pkg::t_item item;
    logic            push;

    always_comb begin
        case (i_cmd)
            pmfa_pkg::CMD_MAP:     item.kind = pmfa_pkg::K_MAP;
            pmfa_pkg::CMD_UNMAP:   item.kind = pmfa_pkg::K_UNMAP;
            pmfa_pkg::CMD_READ:    item.kind = pmfa_pkg::K_READ;
            pmfa_pkg::CMD_WRITE:   item.kind = pmfa_pkg::K_WRITE;
            pmfa_pkg::CMD_RELEASE: item.kind = pmfa_pkg::K_REL;
            default:               item.kind = pmfa_pkg::K_NOP;
        endcase
        if (item.kind != pmfa_pkg::K_NOP && 32'(i_pid) >= PROCESSES) begin
            item.kind = pmfa_pkg::K_BADPID;
        end
        item.pid    = i_pid;
        item.vpn    = i_vaddr[21:12];
        item.offset = i_vaddr[11:0];
        item.count  = i_page_count;
        item.flags  = i_flags;
        item.wbyte  = i_write_byte;
    end

    assign o_in_ready = i_stat.init_done && (r_cnt != 2'd2);
    assign push       = i_in_valid && o_in_ready;
    assign n_cnt      = r_cnt + {1'b0, push} - {1'b0, i_stat.pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_stat.pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.item  = r_q[r_rp];

    `PMFA_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
    `PMFA_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_stat.pop, r_cnt != 2'd0)
endmodule

FILE: hw/rtl/pmfa_back.sv
// Back end: sequencer over the page table and frame map, with result register.
`include "paged_mmu_frame_allocator_unit_macros.svh"
module pmfa_back #(
    parameter int PROCESSES         = pmfa_pkg::PROCESSES_DEF,
    parameter int PAGES_PER_PROCESS = pmfa_pkg::PAGES_DEF,
    parameter int FRAME_COUNT       = pmfa_pkg::FRAME_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [11:0]           i_first_frame,
    input  pmfa_pkg::t_q_out      i_q,
    output pmfa_pkg::t_back_stat  o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_fault,
    output logic [23:0]           o_phys_addr,
    output logic                  o_mem_write,
    output logic [7:0]            o_mem_data
);
    localparam int PT_DEPTH = PROCESSES * PAGES_PER_PROCESS;
    localparam int PT_AW    = $clog2(PT_DEPTH);
    localparam int FR_AW    = $clog2(FRAME_COUNT);
    localparam int CLR_N    = (PT_DEPTH > FRAME_COUNT) ? PT_DEPTH : FRAME_COUNT;
    localparam int CLR_W    = $clog2(CLR_N);

    typedef enum logic [9:0] {
        S_CLEAR    = 10'b0000000001,
        S_IDLE     = 10'b0000000010,
        S_PT_RD    = 10'b0000000100,
        S_PT_CHK   = 10'b0000001000,
        S_SRCH_RD  = 10'b0000010000,
        S_SRCH_CHK = 10'b0000100000,
        S_FR_CHK   = 10'b0001000000,
        S_KILL_RD  = 10'b0010000000,
        S_KILL_WR  = 10'b0100000000,
        S_DONE     = 10'b1000000000
    } t_state;

    t_state                  r_state, n_state;
    logic [CLR_W-1:0]        r_clr;
    pmfa_pkg::t_item         r_it;
    logic [PT_AW-1:0]        r_base;
    logic [12:0]             r_i, n_i;
    logic [pmfa_pkg::FCNT_W-1:0] r_f, n_f;
    logic [14:0]             r_e, n_e;
    logic                    r_flt, n_flt;
    logic [23:0]             r_phys, n_phys;
    logic                    r_mw, n_mw;
    logic [7:0]              r_md, n_md;
    logic                    r_ov;

    logic                    pt_we, fr_we, fr_wdata;
    logic [PT_AW-1:0]        pt_waddr, pt_raddr, pg_addr;
    logic [14:0]             pt_wdata, pt_rdata;
    logic [FR_AW-1:0]        fr_waddr, fr_raddr;
    logic                    fr_rdata;
    logic [12:0]             page;
    logic [11:0]             ef, rd_ef;
    logic                    rd_ef_ok, last_pg, is_map, pop, out_load;
    logic [pmfa_pkg::FCNT_W-1:0] start_f;

    pmfa_ram #(.WIDTH(15), .DEPTH(PT_DEPTH)) u_pt (
        .i_clk  (i_clk),
        .i_we   (pt_we),
        .i_waddr(pt_waddr),
        .i_wdata(pt_wdata),
        .i_raddr(pt_raddr),
        .o_rdata(pt_rdata)
    );

    pmfa_ram #(.WIDTH(1), .DEPTH(FRAME_COUNT)) u_fr (
        .i_clk  (i_clk),
        .i_we   (fr_we),
        .i_waddr(fr_waddr),
        .i_wdata(fr_wdata),
        .i_raddr(fr_raddr),
        .o_rdata(fr_rdata)
    );

    assign is_map   = (r_it.kind == pmfa_pkg::K_MAP);
    assign page     = (r_it.kind == pmfa_pkg::K_MAP || r_it.kind == pmfa_pkg::K_UNMAP)
                      ? (13'(r_it.vpn) + r_i) : 13'(r_it.vpn);
    assign pg_addr  = r_base + PT_AW'(page);
    assign last_pg  = ((r_i + 13'd1) == 13'(r_it.count));
    assign ef       = r_e[14:3];
    assign rd_ef    = pt_rdata[14:3];
    assign rd_ef_ok = (rd_ef != 12'd0) && (32'(rd_ef) < FRAME_COUNT);
    assign start_f  = (i_first_frame == 12'd0) ? pmfa_pkg::FCNT_W'(1)
                                               : pmfa_pkg::FCNT_W'(i_first_frame);
    assign out_load = (r_state == S_DONE) && (!r_ov || i_out_ready);
    assign pop      = (r_state == S_IDLE) && i_q.valid;

    assign o_stat.pop       = pop;
    assign o_stat.init_done = (r_state != S_CLEAR);

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_f      = r_f;
        n_e      = r_e;
        n_flt    = r_flt;
        n_phys   = r_phys;
        n_mw     = r_mw;
        n_md     = r_md;
        pt_we    = 1'b0;
        pt_waddr = pg_addr;
        pt_wdata = 15'd0;
        pt_raddr = pg_addr;
        fr_we    = 1'b0;
        fr_waddr = FR_AW'(ef);
        fr_wdata = 1'b1;
        fr_raddr = FR_AW'(ef);
        case (r_state)
            S_CLEAR: begin
                pt_we    = (32'(r_clr) < PT_DEPTH);
                pt_waddr = PT_AW'(r_clr);
                fr_we    = (32'(r_clr) < FRAME_COUNT);
                fr_waddr = FR_AW'(r_clr);
                if (32'(r_clr) == CLR_N - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q.valid) begin
                    n_i    = 13'd0;
                    n_flt  = 1'b0;
                    n_phys = 24'd0;
                    n_mw   = 1'b0;
                    n_md   = 8'd0;
                    case (i_q.item.kind)
                        pmfa_pkg::K_BADPID: begin
                            n_flt   = 1'b1;
                            n_state = S_DONE;
                        end
                        pmfa_pkg::K_MAP, pmfa_pkg::K_UNMAP: begin
                            n_state = (i_q.item.count == 11'd0) ? S_DONE : S_PT_RD;
                        end
                        pmfa_pkg::K_READ, pmfa_pkg::K_WRITE: n_state = S_PT_RD;
                        pmfa_pkg::K_REL: n_state = S_KILL_RD;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_PT_RD: begin
                if (32'(page) >= PAGES_PER_PROCESS) begin
                    n_flt   = 1'b1;
                    n_i     = 13'd0;
                    n_state = S_KILL_RD;
                end else begin
                    n_state = S_PT_CHK;
                end
            end
            S_PT_CHK: begin
                n_e = pt_rdata;
                if (is_map) begin
                    if (pt_rdata != 15'd0) begin
                        n_flt   = 1'b1;
                        n_i     = 13'd0;
                        n_state = S_KILL_RD;
                    end else begin
                        n_f     = start_f;
                        n_state = S_SRCH_RD;
                    end
                end else if (!rd_ef_ok) begin
                    n_flt   = 1'b1;
                    n_i     = 13'd0;
                    n_state = S_KILL_RD;
                end else begin
                    fr_raddr = FR_AW'(rd_ef);
                    n_state  = S_FR_CHK;
                end
            end
            S_SRCH_RD: begin
                fr_raddr = FR_AW'(r_f);
                if (32'(r_f) >= FRAME_COUNT) begin
                    n_flt   = 1'b1;
                    n_i     = 13'd0;
                    n_state = S_KILL_RD;
                end else begin
                    n_state = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK: begin
                if (fr_rdata) begin
                    // claim the frame and fill the entry
                    fr_we    = 1'b1;
                    fr_waddr = FR_AW'(r_f);
                    fr_wdata = 1'b0;
                    pt_we    = 1'b1;
                    pt_wdata = {r_f[11:0], r_it.flags};
                    n_i      = r_i + 13'd1;
                    n_state  = last_pg ? S_DONE : S_PT_RD;
                end else begin
                    n_f     = r_f + pmfa_pkg::FCNT_W'(1);
                    n_state = S_SRCH_RD;
                end
            end
            S_FR_CHK: begin
                if (r_it.kind == pmfa_pkg::K_UNMAP) begin
                    if (fr_rdata) begin
                        n_flt   = 1'b1;
                        n_i     = 13'd0;
                        n_state = S_KILL_RD;
                    end else begin
                        fr_we   = 1'b1;
                        pt_we   = 1'b1;
                        n_i     = r_i + 13'd1;
                        n_state = last_pg ? S_DONE : S_PT_RD;
                    end
                end else if (fr_rdata ||
                             !((r_it.kind == pmfa_pkg::K_READ) ? r_e[0] : r_e[1])) begin
                    n_flt   = 1'b1;
                    n_i     = 13'd0;
                    n_state = S_KILL_RD;
                end else begin
                    n_phys  = {ef, r_it.offset};
                    n_mw    = (r_it.kind == pmfa_pkg::K_WRITE);
                    n_md    = (r_it.kind == pmfa_pkg::K_WRITE) ? r_it.wbyte : 8'd0;
                    n_state = S_DONE;
                end
            end
            S_KILL_RD: begin
                pt_raddr = r_base + PT_AW'(r_i);
                n_state  = S_KILL_WR;
            end
            S_KILL_WR: begin
                // free the held frame and clear the entry
                pt_we    = 1'b1;
                pt_waddr = r_base + PT_AW'(r_i);
                fr_we    = rd_ef_ok;
                fr_waddr = FR_AW'(rd_ef);
                if (32'(r_i) == PAGES_PER_PROCESS - 1) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + 13'd1;
                    n_state = S_KILL_RD;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + CLR_W'(1);
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_f    <= n_f;
        r_e    <= n_e;
        r_flt  <= n_flt;
        r_phys <= n_phys;
        r_mw   <= n_mw;
        r_md   <= n_md;
        if (pop) begin
            r_it   <= i_q.item;
            r_base <= PT_AW'(32'(i_q.item.pid) * PAGES_PER_PROCESS);
        end
        if (out_load) begin
            o_fault     <= r_flt;
            o_phys_addr <= r_phys;
            o_mem_write <= r_mw;
            o_mem_data  <= r_md;
        end
    end

    assign o_out_valid = r_ov;

    `PMFA_ASSERT_IMP(a_no_pop_clear, i_clk, i_rst_n, r_state == S_CLEAR, !pop)
    `PMFA_ASSERT_IMP(a_wr_no_fault, i_clk, i_rst_n, o_out_valid && o_mem_write, !o_fault)
    `PMFA_ASSERT_NXT(a_pop_busy, i_clk, i_rst_n, pop, r_state != S_IDLE)
endmodule

FILE: hw/rtl/paged_mmu_frame_allocator_unit.sv
// Top level of the paged MMU frame allocator.
// After reset the block sweeps all max(PROCESSES*PAGES_PER_PROCESS, FRAME_COUNT)
// entries of its page table and frame map (65536 by default) and accepts no item
// until done; config writes are taken throughout. Each item gives one result.
// A read or write access steps through page table read, frame map read, result.
// A map checks each page's table entry; the free frame search reads the frame map
// one entry at a time starting at the configured first frame (1 if that is zero).
// An unmap checks the table entry and frame map entry of each page. A release or
// any fault but a bad process id clears the whole table of the process, entry by entry.
// A two-entry queue lets new items enter while the sequencer is busy.
module paged_mmu_frame_allocator_unit #(
    parameter int PROCESSES         = pmfa_pkg::PROCESSES_DEF,
    parameter int PAGES_PER_PROCESS = pmfa_pkg::PAGES_DEF,
    parameter int FRAME_COUNT       = pmfa_pkg::FRAME_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [5:0]  i_pid,
    input  logic [21:0] i_vaddr,
    input  logic [10:0] i_page_count,
    input  logic [2:0]  i_flags,
    input  logic [7:0]  i_write_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_fault,
    output logic [23:0] o_phys_addr,
    output logic        o_mem_write,
    output logic [7:0]  o_mem_data
);
    logic [11:0]          r_first;
    pmfa_pkg::t_q_out     q;
    pmfa_pkg::t_back_stat stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= pmfa_pkg::FIRST_FRAME_RST;
        end else if (i_cfg_valid) begin
            r_first <= i_cfg_data;
        end
    end

    pmfa_front #(.PROCESSES(PROCESSES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_pid       (i_pid),
        .i_vaddr     (i_vaddr),
        .i_page_count(i_page_count),
        .i_flags     (i_flags),
        .i_write_byte(i_write_byte),
        .i_stat      (stat),
        .o_q         (q)
    );

    pmfa_back #(
        .PROCESSES        (PROCESSES),
        .PAGES_PER_PROCESS(PAGES_PER_PROCESS),
        .FRAME_COUNT      (FRAME_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_first_frame(r_first),
        .i_q          (q),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_fault      (o_fault),
        .o_phys_addr  (o_phys_addr),
        .o_mem_write  (o_mem_write),
        .o_mem_data   (o_mem_data)
    );
endmodule
